FILE: rtl/rfba_pkg.sv
`default_nettype none
package rfba_pkg;

  localparam int TOTAL_BLOCKS    = 32;
  localparam int RESERVED_BLOCKS = 8;
  localparam int DATA_BLOCKS     = (TOTAL_BLOCKS > RESERVED_BLOCKS) ?
                                   (TOTAL_BLOCKS - RESERVED_BLOCKS) : 0;
  localparam int DIV_D           = (DATA_BLOCKS == 0) ? 1 : DATA_BLOCKS;
  localparam int IDX_W           = (DIV_D > 1) ? $clog2(DIV_D) : 1;
  localparam int FREE_W          = $clog2(DIV_D + 1);
  localparam int CMP_W           = (FREE_W > 5) ? FREE_W : 5;
  localparam int BLK_SUM_W       = ($clog2(TOTAL_BLOCKS) > 5) ? $clog2(TOTAL_BLOCKS) : 5;
  localparam int MAX_GRANT       = 24;

  localparam logic [15:0] SEED_RESET = 16'd1234;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  // floor(2^32 / D) + 1: exact quotient for every 16-bit dividend
  localparam longint unsigned RECIP_L = ((64'd1 << 32) / DIV_D) + 64'd1;
  localparam logic [32:0]     RECIP   = RECIP_L[32:0];

  localparam logic [1:0] STAT_GRANTED = 2'd0;
  localparam logic [1:0] STAT_INSUFF  = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  typedef struct packed {
    logic start_grant;
    logic emit_empty;
    logic emit_insuff;
    logic mul;
    logic reduce;
    logic load_seed;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic req_insuff;
    logic hit;
    logic hit_last;
  } stat_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/random_free_block_allocator.sv
// Random free-block allocator.
// Request channel: in_request_size is taken at a rising edge with start high
// and busy low. Results leave on out_block_number / out_status / out_last,
// each present for exactly one cycle while out_valid is high; the receiver
// must take every item as it comes, there is no back-pressure.
// A zero request or a request that cannot be met gives a single item in the
// cycle after acceptance, and busy stays low.
// A granted request draws LFSR values in turn, each draw going through a
// reciprocal multiply (S_MUL), then remainder and busy-map lookup (S_RED); a
// free draw gives an item in the following cycle, a busy draw is retried,
// until n blocks are granted. busy falls with the last item.
// Seed channel: cfg_random_seed is written when cfg_valid and cfg_ready are
// both high; cfg_ready is high whenever the block is idle. The write reloads
// the LFSR at once, a zero seed loading the reset seed.
// Reset (synchronous, rst_n low): every data block free, the LFSR holding
// the reset seed, no item pending. No clearing pass is needed.
`default_nettype none
module random_free_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  in_request_size,
  output logic             out_valid,
  output logic [4:0]       out_block_number,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_random_seed
);
  import rfba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  rfba_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_request_size  (in_request_size),
    .cfg_random_seed  (cfg_random_seed),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_block_number (out_block_number),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

FILE: rtl/rfba_ctrl.sv
`default_nettype none
module rfba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           cfg_valid,
  input  wire rfba_pkg::stat_t stat,
  output rfba_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                cfg_ready
);
  import rfba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_seed = cfg_valid && cfg_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.req_zero) begin
            cmd.emit_empty = 1'b1;
          end else if (stat.req_insuff) begin
            cmd.emit_insuff = 1'b1;
          end else begin
            cmd.start_grant = 1'b1;
            state_nxt       = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RED;
      end
      S_RED: begin
        cmd.reduce = 1'b1;
        state_nxt  = (stat.hit && stat.hit_last) ? S_IDLE : S_MUL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rfba_dpath.sv
`default_nettype none
module rfba_dpath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rfba_pkg::cmd_t cmd,
  input  wire logic [4:0]     in_request_size,
  input  wire logic [15:0]    cfg_random_seed,
  output rfba_pkg::stat_t     stat,
  output logic                out_valid,
  output logic [4:0]          out_block_number,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import rfba_pkg::*;

  logic [15:0]          lfsr_r, lfsr_nxt;
  logic [15:0]          q_r;
  logic [4:0]           req_r;
  logic [4:0]           cnt_r;
  logic [FREE_W-1:0]    free_r;
  logic [DIV_D-1:0]     busy_map_r;
  logic                 out_valid_r;
  logic [4:0]           out_blk_r;
  logic [1:0]           out_stat_r;
  logic                 out_last_r;

  logic [48:0]          prod;
  logic [23:0]          qd;
  logic [23:0]          r_raw;
  logic [23:0]          r_fix;
  logic [IDX_W-1:0]     idx;
  logic [BLK_SUM_W-1:0] blk_sum;
  logic [CMP_W-1:0]     req_ext;
  logic [CMP_W-1:0]     free_ext;
  logic [15:0]          seed_ld;

  assign prod    = 49'(lfsr_r) * 49'(RECIP);
  assign qd      = 24'(q_r) * 24'(DIV_D);
  assign r_raw   = 24'(lfsr_r) - qd;
  assign r_fix   = (r_raw >= 24'(DIV_D)) ? (r_raw - 24'(DIV_D)) : r_raw;
  assign idx     = r_fix[IDX_W-1:0];
  assign blk_sum = BLK_SUM_W'(idx) + BLK_SUM_W'(RESERVED_BLOCKS);

  assign req_ext  = CMP_W'(in_request_size);
  assign free_ext = CMP_W'(free_r);

  assign stat.req_zero   = (in_request_size == 5'd0);
  assign stat.req_insuff = (req_ext > free_ext) || (in_request_size > 5'(MAX_GRANT)) ||
                           (DATA_BLOCKS == 0);
  assign stat.hit        = !busy_map_r[idx];
  assign stat.hit_last   = ((cnt_r + 5'd1) == req_r);

  assign seed_ld = (cfg_random_seed == 16'd0) ? SEED_RESET : cfg_random_seed;

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (cmd.load_seed && cmd.start_grant) begin
      lfsr_nxt = lfsr_step(seed_ld);
    end else if (cmd.load_seed) begin
      lfsr_nxt = seed_ld;
    end else if (cmd.start_grant) begin
      lfsr_nxt = lfsr_step(lfsr_r);
    end else if (cmd.reduce && !(stat.hit && stat.hit_last)) begin
      lfsr_nxt = lfsr_step(lfsr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= SEED_RESET;
      free_r      <= FREE_W'(DATA_BLOCKS);
      busy_map_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
    end else begin
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= cmd.emit_empty || cmd.emit_insuff || (cmd.reduce && stat.hit);
      if (cmd.start_grant) begin
        cnt_r <= 5'd0;
      end
      if (cmd.reduce && stat.hit) begin
        busy_map_r[idx] <= 1'b1;
        free_r          <= free_r - FREE_W'(1);
        cnt_r           <= cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_grant) begin
      req_r <= in_request_size;
    end
    if (cmd.mul) begin
      q_r <= prod[47:32];
    end
    if (cmd.emit_empty) begin
      out_blk_r  <= 5'd0;
      out_stat_r <= STAT_EMPTY;
      out_last_r <= 1'b1;
    end else if (cmd.emit_insuff) begin
      out_blk_r  <= 5'd0;
      out_stat_r <= STAT_INSUFF;
      out_last_r <= 1'b1;
    end else if (cmd.reduce && stat.hit) begin
      out_blk_r  <= blk_sum[4:0];
      out_stat_r <= STAT_GRANTED;
      out_last_r <= stat.hit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_number = out_blk_r;
  assign out_status       = out_stat_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/rfba_checker.sv
`default_nettype none
module rfba_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [4:0]  out_block_number,
  input wire logic [1:0]  out_status,
  input wire logic        out_last
);
  import rfba_pkg::*;

  a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_GRANTED) |-> out_last)
    else $error("non-granted item without last");

  a_reject_zero_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_GRANTED) |-> (out_block_number == 5'd0))
    else $error("non-granted item with block number");

  a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item produced neither busy nor result");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy still high with final item");

endmodule

bind random_free_block_allocator rfba_checker u_rfba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_block_number (out_block_number),
  .out_status       (out_status),
  .out_last         (out_last)
);
`default_nettype wire

FILE: tb/sv/tb_random_free_block_allocator.sv
module tb_random_free_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import rfba_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_PHASES = 5;

  typedef struct packed {
    logic [4:0] block_number;
    logic [1:0] status;
    logic       last;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  in_request_size = '0;
  logic        out_valid;
  logic [4:0]  out_block_number;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_random_seed = '0;

  alloc_result_t            expected_allocs[$];
  logic [4:0]               pending_reqs[$];
  int                       n_issued = 0;
  int                       n_taken = 0;
  int                       mismatches = 0;
  int                       quiet_cycles = 0;
  int                       sender_idle_pct = 0;
  int                       plan_free = DATA_BLOCKS;
  logic [15:0]              model_lfsr = SEED_RESET;
  logic [TOTAL_BLOCKS-1:0]  model_taken = '0;
  int                       model_free = DATA_BLOCKS;

  random_free_block_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_block_number (out_block_number),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_random_seed  (cfg_random_seed)
  );

  always #5 clk = ~clk;

  task automatic allocate_blocks(input logic [4:0] n);
    alloc_result_t r;
    int            k;
    int            slot;
    r.block_number = '0;
    r.last         = 1'b1;
    if (n == 0) begin
      r.status = STAT_EMPTY;
      expected_allocs.push_back(r);
    end else if (n > model_free || n > MAX_GRANT || DATA_BLOCKS == 0) begin
      r.status = STAT_INSUFF;
      expected_allocs.push_back(r);
    end else begin
      k = 0;
      while (k < n) begin
        model_lfsr = (model_lfsr >> 1) ^ (model_lfsr[0] ? LFSR_TAPS : 16'h0000);
        slot = model_lfsr % DATA_BLOCKS;
        if (!model_taken[slot]) begin
          model_taken[slot] = 1'b1;
          model_free--;
          r.block_number = 5'(slot + RESERVED_BLOCKS);
          r.status       = STAT_GRANTED;
          r.last         = (k + 1 == n);
          expected_allocs.push_back(r);
          k++;
        end
      end
    end
  endtask

  // planned free count tracks grants so that the stimulus keeps some requests satisfiable
  task automatic queue_request(input logic [4:0] n);
    pending_reqs.push_back(n);
    if (n != 0 && n <= plan_free && n <= MAX_GRANT) begin
      plan_free -= n;
    end
  endtask

  function automatic logic [4:0] pick_size();
    int roll;
    int cap;
    roll = $urandom_range(99);
    cap  = (plan_free < 3) ? plan_free : 3;
    if (roll < 40 && plan_free > 0) begin
      if ($urandom_range(19) == 0) begin
        return 5'($urandom_range(plan_free, 1));
      end
      return 5'($urandom_range(cap, 1));
    end
    if (roll < 55) begin
      return 5'd0;
    end
    if (roll < 70) begin
      return 5'(plan_free + 1);
    end
    if (roll < 80) begin
      return 5'($urandom);
    end
    return 5'($urandom_range(31, plan_free + 1));
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || n_taken != n_issued ||
           expected_allocs.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_seed(input logic [15:0] s);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_random_seed <= s;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid       <= 1'b0;
    cfg_random_seed <= 16'($urandom);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!(start && n_taken != n_issued)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        start           <= 1'b1;
        in_request_size <= pending_reqs.pop_front();
        n_issued++;
      end else begin
        start           <= 1'b0;
        in_request_size <= 5'($urandom);
      end
    end
  end

  // result monitor, prediction and watchdog
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid) begin
        if (expected_allocs.size() == 0) begin
          $display("%0t: unexpected item blk %0d status %0d last %0d", $time,
                   out_block_number, out_status, out_last);
          mismatches++;
        end else begin
          want = expected_allocs.pop_front();
          if (out_block_number !== want.block_number) begin
            $display("%0t: block_number expected %0d got %0d", $time,
                     want.block_number, out_block_number);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, out_last);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        model_lfsr = (cfg_random_seed == 16'h0000) ? SEED_RESET : cfg_random_seed;
      end
      if (start && !busy) begin
        allocate_blocks(in_request_size);
        n_taken++;
      end
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("random_free_block_allocator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int          ph;
    int          idle_plan[NUM_PHASES];
    int          item_plan[NUM_PHASES];
    logic [15:0] seed_plan[NUM_PHASES];
    idle_plan = '{0, 58, 10, 0, 58};
    item_plan = '{45, 60, 60, 60, 55};
    seed_plan = '{SEED_RESET, 16'h0000, 16'hFFFF, 16'h0001,
                  16'($urandom_range(65535, 1))};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_seed(seed_plan[ph]);
      end
      sender_idle_pct = idle_plan[ph];
      if (ph == 0) begin
        queue_request(5'd0);
        queue_request(5'd31);
        queue_request(5'd25);
        queue_request(5'd1);
        queue_request(5'd2);
        queue_request(5'd24);
        queue_request(5'd0);
      end
      repeat (item_plan[ph]) queue_request(pick_size());
    end
    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("random_free_block_allocator regression: pass");
    end else begin
      $display("random_free_block_allocator regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rfba_pkg.sv
rtl/rfba_ctrl.sv
rtl/rfba_dpath.sv
rtl/random_free_block_allocator.sv
rtl/rfba_checker.sv
tb/sv/tb_random_free_block_allocator.sv
